FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the dab spacing stepper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BDSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BDSS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BDSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BDSS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: hdl/bdss_pkg.sv
// ----------------------------------------------------------------------------
// bdss_pkg
// Shared types and constants of the brush dab spacing stepper.
// ----------------------------------------------------------------------------
`default_nettype none
package bdss_pkg;
    localparam int AW            = 96;  // shared unit datapath width
    localparam int QW            = 48;  // quotient / root register width
    localparam int CNT_W         = 7;   // unit step counter width
    localparam int POS_W         = 46;
    localparam int OUT_W         = 45;
    localparam int LW            = 47;  // length, delta magnitude, dab count
    localparam int STW           = 25;  // per-axis step magnitude
    localparam int SPACING_RECIP = 20;

    localparam logic [2:0] CFG_SPACING = 3'd0;
    localparam logic [2:0] CFG_ZOOM    = 3'd1;
    localparam logic [2:0] CFG_OFFX    = 3'd2;
    localparam logic [2:0] CFG_OFFY    = 3'd3;
    localparam logic [2:0] CFG_HEIGHT  = 3'd4;

    typedef enum logic [2:0] {
        CMD_HOVER      = 3'd0,
        CMD_PRESS_NEW  = 3'd1,
        CMD_PRESS_CONT = 3'd2,
        CMD_DRAG       = 3'd3,
        CMD_RELEASE    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT,
        OP_ADD
    } t_op;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [CNT_W-1:0] steps;
    } t_unit_req;
endpackage
`default_nettype wire

FILE: hdl/bdss_unit.sv
// ----------------------------------------------------------------------------
// bdss_unit
// Shared iterative arithmetic unit: shift-add multiply, restoring divide,
// digit-by-digit square root and single add, one step per cycle on one adder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module bdss_unit import bdss_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_unit_req     i_req,
    input  wire logic [AW-1:0] i_opa,
    input  wire logic [AW-1:0] i_opb,
    input  wire logic [AW-1:0] i_opc,
    output logic               o_done,
    output logic [AW-1:0]      o_acc,
    output logic [QW-1:0]      o_q
);
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_op              r_op;
    logic [AW-1:0]    r_acc;
    logic [AW-1:0]    r_a;
    logic [AW-1:0]    r_b;
    logic [QW-1:0]    r_q;

    logic [AW-1:0] w_x;
    logic [AW-1:0] w_y;
    logic          w_sub;
    logic [AW:0]   w_sum;
    logic          w_ge;

    always_comb begin
        unique case (r_op)
            OP_MUL: begin
                w_x   = {r_acc[AW-2:0], 1'b0};
                w_y   = r_b[AW-1] ? r_a : '0;
                w_sub = 1'b0;
            end
            OP_DIV: begin
                w_x   = {r_acc[AW-2:0], r_b[AW-1]};
                w_y   = r_a;
                w_sub = 1'b1;
            end
            OP_SQRT: begin
                w_x   = {r_acc[AW-3:0], r_b[AW-1:AW-2]};
                w_y   = {{(AW-QW-2){1'b0}}, r_q, 2'b01};
                w_sub = 1'b1;
            end
            default: begin
                w_x   = r_a;
                w_y   = r_b;
                w_sub = 1'b0;
            end
        endcase
        w_sum = {1'b0, w_x} + {1'b0, (w_sub ? ~w_y : w_y)} + (AW+1)'(w_sub);
        w_ge  = w_sum[AW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_op   <= i_req.op;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_opa;
            r_b   <= i_opb;
            r_acc <= i_opc;
            r_q   <= '0;
        end else if (r_busy) begin
            unique case (r_op)
                OP_MUL: begin
                    r_acc <= w_sum[AW-1:0];
                    r_b   <= r_b << 1;
                end
                OP_DIV: begin
                    r_acc <= w_ge ? w_sum[AW-1:0] : w_x;
                    r_q   <= {r_q[QW-2:0], w_ge};
                    r_b   <= r_b << 1;
                end
                OP_SQRT: begin
                    r_acc <= w_ge ? w_sum[AW-1:0] : w_x;
                    r_q   <= {r_q[QW-2:0], w_ge};
                    r_b   <= r_b << 2;
                end
                default: begin
                    r_acc <= w_sum[AW-1:0];
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
    assign o_q    = r_q;

    `BDSS_ASSERT_NEVER(a_start_busy, i_clk, i_rst_n, i_req.start && r_busy, "start while busy")
    `BDSS_ASSERT(a_done_busy, i_clk, i_rst_n, r_done |-> $past(r_busy), "done without work")
    `BDSS_ASSERT(a_steps_nz, i_clk, i_rst_n, i_req.start |-> i_req.steps != '0, "zero steps")
endmodule
`default_nettype wire

FILE: hdl/brush_dab_spacing_stepper_top.sv
// A first stroke sample gives its dab in the cycle after acceptance. Other
// motions run in the shared unit (two squares, add, root, count divide, per
// axis a multiply, add and divide, two end-point multiplies), then dabs leave
// at one per cycle while the output is ready. Input is taken only when idle.
// Reset: synchronous active-low, loads register and stroke state defaults.
// ----------------------------------------------------------------------------
// brush_dab_spacing_stepper_top
// Maps pointer events to canvas space and emits evenly spaced dab centres.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module brush_dab_spacing_stepper_top import bdss_pkg::*; #(
    parameter int MAX_DABS      = 64,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // pointer_x [15:0], pointer_y [31:16]
    input  wire logic [2:0]  i_s_tuser,   // command [2:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [95:0]      o_m_tdata,   // dab_x [44:0], dab_y [89:45], zero
    output logic             o_m_tlast,   // last_dab
    output logic [0:0]       o_m_tuser,   // dabs_dropped [0]
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);
    localparam int KW  = $clog2(MAX_DABS + 1);
    localparam int SHW = $clog2(FRACTION_BITS + 16);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SUMD, ST_ROOT, ST_COUNT,
        ST_MULX, ST_ADDX, ST_DIVX, ST_MULY, ST_ADDY, ST_DIVY,
        ST_ENDX, ST_ENDY, ST_EMIT
    } t_state;

    t_state             r_state;
    logic [23:0]        r_spacing;
    logic [3:0]         r_zoom;
    logic signed [20:0] r_offx;
    logic signed [20:0] r_offy;
    logic [13:0]        r_height;
    logic               r_active;
    logic               r_fresh;
    logic [POS_W-1:0]   r_lx;
    logic [POS_W-1:0]   r_ly;
    logic [LW-1:0]      r_ux;
    logic [LW-1:0]      r_uy;
    logic               r_sx;
    logic               r_sy;
    logic [AW-1:0]      r_d2;
    logic [LW-1:0]      r_len;
    logic [LW-1:0]      r_n;
    logic [STW-1:0]     r_qx;
    logic [STW-1:0]     r_qy;
    logic [POS_W-1:0]   r_ex;
    logic [POS_W-1:0]   r_stx;
    logic [POS_W-1:0]   r_sty;
    logic [POS_W-1:0]   r_px;
    logic [POS_W-1:0]   r_py;
    logic [KW-1:0]      r_k;
    logic [KW-1:0]      r_kmax;
    logic               r_drop;
    logic               r_ovalid;
    logic               r_olast;
    logic               r_ouser;
    t_unit_req          r_req;
    logic [AW-1:0]      r_opa;
    logic [AW-1:0]      r_opb;
    logic [AW-1:0]      r_opc;

    logic          w_done;
    logic [AW-1:0] w_acc;
    logic [QW-1:0] w_q;

    bdss_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_opa   (r_opa),
        .i_opb   (r_opb),
        .i_opc   (r_opc),
        .o_done  (w_done),
        .o_acc   (w_acc),
        .o_q     (w_q)
    );

    // input mapping
    logic signed [15:0] w_ptx;
    logic signed [15:0] w_pty;
    logic [SHW-1:0]     w_sh;
    logic signed [21:0] w_tx;
    logic signed [21:0] w_ty0;
    logic signed [22:0] w_ty;
    logic [POS_W-1:0]   w_cx;
    logic [POS_W-1:0]   w_cy;
    logic [28:0]        w_s20;
    logic [31:0]        w_p2;
    logic               w_small;
    logic signed [LW-1:0] w_dx;
    logic signed [LW-1:0] w_dy;
    logic               w_act;
    logic               w_fresh;
    logic               w_motion;
    logic               w_go;
    logic               w_accept;
    logic [LW-1:0]      w_len_m;
    logic [POS_W-1:0]   w_p;
    logic [POS_W-1:0]   w_ey;
    logic [POS_W-1:0]   w_stx;
    logic [POS_W-1:0]   w_sty;
    logic [KW-1:0]      w_kmax;
    logic               w_drop;
    logic [KW-1:0]      w_knext;

    always_comb begin
        w_ptx   = i_s_tdata[15:0];
        w_pty   = i_s_tdata[31:16];
        w_sh    = SHW'(FRACTION_BITS) + SHW'(r_zoom);
        w_tx    = 22'(w_ptx) + 22'(r_offx);
        w_ty0   = 22'(w_pty) - 22'(r_offy);
        w_ty    = $signed({9'd0, r_height}) - 23'(w_ty0);
        w_cx    = POS_W'(w_tx) << w_sh;
        w_cy    = POS_W'(w_ty) << w_sh;
        w_s20   = 29'(r_spacing) * 29'(SPACING_RECIP);
        w_p2    = 32'd1 << w_sh;
        w_small = 32'(w_s20) < w_p2;
        w_dx    = LW'($signed(w_cx)) - LW'($signed(r_lx));
        w_dy    = LW'($signed(w_cy)) - LW'($signed(r_ly));

        w_act    = r_active;
        w_fresh  = r_fresh;
        w_motion = 1'b0;
        unique case (t_cmd'(i_s_tuser))
            CMD_HOVER, CMD_DRAG: w_motion = 1'b1;
            CMD_PRESS_NEW: begin
                w_act    = 1'b1;
                w_motion = 1'b1;
            end
            CMD_PRESS_CONT: begin
                w_act    = 1'b1;
                w_fresh  = 1'b0;
                w_motion = 1'b1;
            end
            CMD_RELEASE: begin
                w_act   = 1'b0;
                w_fresh = 1'b1;
            end
            default: w_motion = 1'b0;
        endcase
        w_go     = w_motion && w_act && !w_small;
        w_accept = i_s_tvalid && (r_state == ST_IDLE);

        w_len_m = (w_acc == '0) ? w_q[LW-1:0] - 1'b1 : w_q[LW-1:0];
        w_p     = w_acc[POS_W-1:0];
        w_ey    = r_ly + (r_sy ? (POS_W'(0) - w_p) : w_p);
        w_stx   = r_sx ? (POS_W'(0) - POS_W'(r_qx)) : POS_W'(r_qx);
        w_sty   = r_sy ? (POS_W'(0) - POS_W'(r_qy)) : POS_W'(r_qy);
        w_drop  = r_n > LW'(MAX_DABS);
        w_kmax  = w_drop ? KW'(MAX_DABS) : r_n[KW-1:0];
        w_knext = r_k + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_spacing   <= 24'd1638;
            r_zoom      <= '0;
            r_offx      <= '0;
            r_offy      <= '0;
            r_height    <= '0;
            r_active    <= 1'b0;
            r_fresh     <= 1'b1;
            r_lx        <= '0;
            r_ly        <= '0;
            r_ovalid    <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            if (r_req.start) begin
                r_req.start <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SPACING: r_spacing <= i_cfg_data;
                    CFG_ZOOM:    r_zoom    <= i_cfg_data[3:0];
                    CFG_OFFX:    r_offx    <= i_cfg_data[20:0];
                    CFG_OFFY:    r_offy    <= i_cfg_data[20:0];
                    CFG_HEIGHT:  r_height  <= i_cfg_data[13:0];
                    default:     r_zoom    <= r_zoom;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_active <= w_act;
                        r_fresh  <= w_fresh && !w_go;
                        if (w_go && w_fresh) begin
                            r_lx     <= w_cx;
                            r_ly     <= w_cy;
                            r_px     <= w_cx;
                            r_py     <= w_cy;
                            r_olast  <= 1'b1;
                            r_ouser  <= 1'b0;
                            r_ovalid <= 1'b1;
                            r_k      <= KW'(1);
                            r_kmax   <= KW'(1);
                            r_state  <= ST_EMIT;
                        end else if (w_go) begin
                            r_sx    <= w_dx[LW-1];
                            r_sy    <= w_dy[LW-1];
                            r_ux    <= w_dx[LW-1] ? LW'(-w_dx) : LW'(w_dx);
                            r_uy    <= w_dy[LW-1] ? LW'(-w_dy) : LW'(w_dy);
                            r_req   <= '{start: 1'b1, op: OP_MUL, steps: CNT_W'(LW)};
                            r_opa   <= AW'(w_dx[LW-1] ? LW'(-w_dx) : LW'(w_dx));
                            r_opb   <= AW'(w_dx[LW-1] ? LW'(-w_dx) : LW'(w_dx)) << (AW - LW);
                            r_opc   <= '0;
                            r_state <= ST_SQX;
                        end
                    end
                end
                ST_SQX: if (w_done) begin
                    r_d2    <= w_acc;
                    r_req   <= '{start: 1'b1, op: OP_MUL, steps: CNT_W'(LW)};
                    r_opa   <= AW'(r_uy);
                    r_opb   <= AW'(r_uy) << (AW - LW);
                    r_opc   <= '0;
                    r_state <= ST_SQY;
                end
                ST_SQY: if (w_done) begin
                    r_req   <= '{start: 1'b1, op: OP_ADD, steps: CNT_W'(1)};
                    r_opa   <= r_d2;
                    r_opb   <= w_acc;
                    r_state <= ST_SUMD;
                end
                ST_SUMD: if (w_done) begin
                    if (w_acc == '0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_req   <= '{start: 1'b1, op: OP_SQRT, steps: CNT_W'(LW)};
                        r_opb   <= w_acc << 2;
                        r_opc   <= '0;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: if (w_done) begin
                    r_len   <= w_q[LW-1:0];
                    r_req   <= '{start: 1'b1, op: OP_DIV, steps: CNT_W'(LW)};
                    r_opa   <= AW'(r_spacing);
                    r_opb   <= AW'(w_len_m) << (AW - LW);
                    r_opc   <= '0;
                    r_state <= ST_COUNT;
                end
                ST_COUNT: if (w_done) begin
                    r_n <= w_q[LW-1:0];
                    if (w_q[LW-1:0] == '0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_req   <= '{start: 1'b1, op: OP_MUL, steps: CNT_W'(STW)};
                        r_opa   <= AW'(r_ux);
                        r_opb   <= AW'({r_spacing, 1'b0}) << (AW - STW);
                        r_opc   <= '0;
                        r_state <= ST_MULX;
                    end
                end
                ST_MULX, ST_MULY: if (w_done) begin
                    r_req   <= '{start: 1'b1, op: OP_ADD, steps: CNT_W'(1)};
                    r_opa   <= w_acc;
                    r_opb   <= AW'(r_len);
                    r_state <= (r_state == ST_MULX) ? ST_ADDX : ST_ADDY;
                end
                ST_ADDX, ST_ADDY: if (w_done) begin
                    r_req   <= '{start: 1'b1, op: OP_DIV, steps: CNT_W'(STW)};
                    r_opa   <= AW'({r_len, 1'b0});
                    r_opb   <= w_acc << (AW - STW);
                    r_opc   <= w_acc >> STW;
                    r_state <= (r_state == ST_ADDX) ? ST_DIVX : ST_DIVY;
                end
                ST_DIVX: if (w_done) begin
                    r_qx    <= w_q[STW-1:0];
                    r_req   <= '{start: 1'b1, op: OP_MUL, steps: CNT_W'(STW)};
                    r_opa   <= AW'(r_uy);
                    r_opb   <= AW'({r_spacing, 1'b0}) << (AW - STW);
                    r_opc   <= '0;
                    r_state <= ST_MULY;
                end
                ST_DIVY: if (w_done) begin
                    r_qy    <= w_q[STW-1:0];
                    r_req   <= '{start: 1'b1, op: OP_MUL, steps: CNT_W'(STW)};
                    r_opa   <= AW'(r_n);
                    r_opb   <= AW'(r_qx) << (AW - STW);
                    r_opc   <= '0;
                    r_state <= ST_ENDX;
                end
                ST_ENDX: if (w_done) begin
                    r_ex    <= r_lx + (r_sx ? (POS_W'(0) - w_p) : w_p);
                    r_req   <= '{start: 1'b1, op: OP_MUL, steps: CNT_W'(STW)};
                    r_opa   <= AW'(r_n);
                    r_opb   <= AW'(r_qy) << (AW - STW);
                    r_opc   <= '0;
                    r_state <= ST_ENDY;
                end
                ST_ENDY: if (w_done) begin
                    r_stx    <= w_stx;
                    r_sty    <= w_sty;
                    r_px     <= r_lx + w_stx;
                    r_py     <= r_ly + w_sty;
                    r_lx     <= r_ex;
                    r_ly     <= w_ey;
                    r_k      <= KW'(1);
                    r_kmax   <= w_kmax;
                    r_drop   <= w_drop;
                    r_olast  <= (w_kmax == KW'(1));
                    r_ouser  <= (w_kmax == KW'(1)) && w_drop;
                    r_ovalid <= 1'b1;
                    r_state  <= ST_EMIT;
                end
                ST_EMIT: if (i_m_tready) begin
                    if (r_olast) begin
                        r_ovalid <= 1'b0;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_px    <= r_px + r_stx;
                        r_py    <= r_py + r_sty;
                        r_k     <= w_knext;
                        r_olast <= (w_knext == r_kmax);
                        r_ouser <= (w_knext == r_kmax) && r_drop;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready   = (r_state == ST_IDLE);
    assign o_m_tvalid   = r_ovalid;
    assign o_m_tdata    = {6'd0, r_py[OUT_W-1:0], r_px[OUT_W-1:0]};
    assign o_m_tlast    = r_olast;
    assign o_m_tuser[0] = r_ouser;

    `BDSS_ASSERT_NEVER(a_ready_pending, i_clk, i_rst_n, o_s_tready && o_m_tvalid, "input ready with dab pending")
    `BDSS_ASSERT(a_drop_last, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser[0]) |-> o_m_tlast, "drop flag off last dab")
    `BDSS_ASSERT(a_last_ends, i_clk, i_rst_n, (o_m_tvalid && i_m_tready && o_m_tlast) |=> !o_m_tvalid, "dab after last")
endmodule
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Brush dab spacing stepper testbench
// Sends pointer events over the slave stream and checks every dab centre on
// the master stream against a predictor of the stroke state. It covers
// directed edge cases and random strokes under several view and spacing
// settings, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic [44:0] x;
    logic [44:0] y;
    logic        last;
    logic        drop;
} t_dab;

class dab_scoreboard;
    logic [23:0]        spacing;
    logic [3:0]         zoom;
    logic signed [20:0] off_x;
    logic signed [20:0] off_y;
    logic [13:0]        height;
    logic signed [45:0] last_x;
    logic signed [45:0] last_y;
    bit                 active;
    bit                 fresh;
    t_dab               pending_dabs[$];
    int                 failures;
    int                 inputs_seen;
    int                 dabs_checked;
    int                 dropped_seen;

    function new();
        spacing = 24'd1638;
        zoom = '0;
        off_x = '0;
        off_y = '0;
        height = '0;
        last_x = '0;
        last_y = '0;
        active = 0;
        fresh = 1;
        failures = 0;
        inputs_seen = 0;
        dabs_checked = 0;
        dropped_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
        case (idx)
            bdss_pkg::CFG_SPACING: spacing = val;
            bdss_pkg::CFG_ZOOM:    zoom = val[3:0];
            bdss_pkg::CFG_OFFX:    off_x = val[20:0];
            bdss_pkg::CFG_OFFY:    off_y = val[20:0];
            bdss_pkg::CFG_HEIGHT:  height = val[13:0];
            default: ;
        endcase
    endfunction

    function logic [63:0] isqrt(logic [127:0] v);
        logic [63:0]  res;
        logic [63:0]  t;
        logic [127:0] t2;
        res = '0;
        for (int i = 63; i >= 0; i--) begin
            t = res | (64'd1 << i);
            t2 = 128'(t) * 128'(t);
            if (t2 <= v) res = t;
        end
        return res;
    endfunction

    function longint axis_step(longint d, logic [63:0] len);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (d < 0) ? 128'(-d) : 128'(d);
        q = (128'(spacing) * 2 * mag + 128'(len)) / (128'(len) * 2);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void push_dab(logic [63:0] x, logic [63:0] y, bit last, bit drop);
        t_dab e;
        e.x = x[44:0];
        e.y = y[44:0];
        e.last = last;
        e.drop = drop;
        pending_dabs.push_back(e);
    endfunction

    function void predict_motion(logic signed [15:0] px, logic signed [15:0] py);
        int unsigned   sh;
        logic [63:0]   t;
        logic signed [45:0] cx;
        logic signed [45:0] cy;
        longint        dx;
        longint        dy;
        logic [127:0]  ux;
        logic [127:0]  uy;
        logic [127:0]  d2;
        logic [63:0]   len;
        logic [63:0]   m;
        logic [63:0]   n;
        longint        stx;
        longint        sty;
        if (!active) return;
        sh = zoom + 8;
        if (64'(spacing) * 20 < (64'd1 << sh)) return;
        t = (longint'(px) + longint'(off_x)) <<< sh;
        cx = t[45:0];
        t = (longint'(height) - (longint'(py) - longint'(off_y))) <<< sh;
        cy = t[45:0];
        if (fresh) begin
            last_x = cx;
            last_y = cy;
            fresh = 0;
            push_dab(64'(cx), 64'(cy), 1, 0);
            return;
        end
        dx = longint'(cx) - longint'(last_x);
        dy = longint'(cy) - longint'(last_y);
        ux = (dx < 0) ? 128'(-dx) : 128'(dx);
        uy = (dy < 0) ? 128'(-dy) : 128'(dy);
        d2 = ux * ux + uy * uy;
        if (d2 == 0) return;
        len = isqrt(d2);
        m = (128'(len) * 128'(len) == d2) ? len - 1 : len;
        n = m / 64'(spacing);
        if (n == 0) return;
        stx = axis_step(dx, len);
        sty = axis_step(dy, len);
        for (longint k = 1; k <= n && k <= 64; k++) begin
            push_dab(longint'(last_x) + k * stx, longint'(last_y) + k * sty,
                     (k == n) || (k == 64), (k == 64) && (n > 64));
        end
        t = longint'(last_x) + longint'(n) * stx;
        last_x = t[45:0];
        t = longint'(last_y) + longint'(n) * sty;
        last_y = t[45:0];
    endfunction

    function void note_input(logic [2:0] cmd, logic signed [15:0] px,
                             logic signed [15:0] py);
        inputs_seen++;
        case (cmd)
            bdss_pkg::CMD_HOVER, bdss_pkg::CMD_DRAG: predict_motion(px, py);
            bdss_pkg::CMD_PRESS_NEW: begin
                active = 1;
                predict_motion(px, py);
            end
            bdss_pkg::CMD_PRESS_CONT: begin
                active = 1;
                fresh = 0;
                predict_motion(px, py);
            end
            bdss_pkg::CMD_RELEASE: begin
                active = 0;
                fresh = 1;
            end
            default: ;
        endcase
    endfunction

    function void check_dab(logic [44:0] x, logic [44:0] y, logic last, logic drop);
        t_dab e;
        dabs_checked++;
        if (drop) dropped_seen++;
        if (pending_dabs.size() == 0) begin
            failures++;
            $display("%0t: unexpected dab x=%h y=%h last=%b drop=%b",
                     $time, x, y, last, drop);
            return;
        end
        e = pending_dabs.pop_front();
        if (e.x !== x || e.y !== y || e.last !== last || e.drop !== drop) begin
            failures++;
            $display("%0t: dab mismatch expected x=%h y=%h last=%b drop=%b",
                     $time, e.x, e.y, e.last, e.drop);
            $display("%0t:                actual x=%h y=%h last=%b drop=%b",
                     $time, x, y, last, drop);
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bdss_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int SETTLE = 420;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic [2:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [95:0] o_m_tdata;
    logic        o_m_tlast;
    logic [0:0]  o_m_tuser;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    dab_scoreboard sb;
    int  cycles;
    int  stall_left;
    bit  no_idle;
    int  cur_x;
    int  cur_y;

    brush_dab_spacing_stepper_top uut (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_dab(o_m_tdata[44:0], o_m_tdata[89:45], o_m_tlast, o_m_tuser[0]);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 0;
        end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            stall_left <= pick_gap();
            i_m_tready <= 0;
        end else begin
            i_m_tready <= 1;
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [23:0] val);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
        sb.write_reg(idx, val);
    endtask

    task automatic wait_idle();
        i_s_tvalid = 0;
        while (sb.pending_dabs.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_view(logic [23:0] spc, logic [3:0] zm, logic [20:0] ox,
                            logic [20:0] oy, logic [13:0] ht);
        wait_idle();
        write_cfg(CFG_SPACING, spc);
        write_cfg(CFG_ZOOM, 24'(zm));
        write_cfg(CFG_OFFX, 24'(ox));
        write_cfg(CFG_OFFY, 24'(oy));
        write_cfg(CFG_HEIGHT, 24'(ht));
    endtask

    task automatic send_event(logic [2:0] cmd, int px, int py);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1;
        i_s_tuser = cmd;
        i_s_tdata = {16'(py), 16'(px)};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(cmd, 16'(px), 16'(py));
        @(negedge i_clk);
    endtask

    function automatic int clamp16(int v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    task automatic random_point(bit wide);
        if (wide) begin
            cur_x = $signed(16'($urandom));
            cur_y = $signed(16'($urandom));
        end else begin
            cur_x = $urandom_range(0, 4000) - 2000;
            cur_y = $urandom_range(0, 4000) - 2000;
        end
    endtask

    task automatic random_stroke();
        int moves;
        random_point($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 9) == 0)
            send_event(CMD_PRESS_CONT, cur_x, cur_y);
        else
            send_event(CMD_PRESS_NEW, cur_x, cur_y);
        moves = $urandom_range(2, 8);
        for (int i = 0; i < moves; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                random_point(1);
            end else begin
                cur_x = clamp16(cur_x + int'($urandom_range(0, 80)) - 40);
                cur_y = clamp16(cur_y + int'($urandom_range(0, 80)) - 40);
            end
            send_event(($urandom_range(0, 3) == 0) ? CMD_HOVER : CMD_DRAG, cur_x, cur_y);
        end
        if ($urandom_range(0, 9) != 0) send_event(CMD_RELEASE, cur_x, cur_y);
    endtask

    initial begin
        int zm;
        int sent;
        sb = new();
        cycles = 0;
        stall_left = 0;
        no_idle = 0;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // reset settings: motion without stroke, unknown commands, first dab, drags, continued press
        send_event(CMD_HOVER, 10, 10);
        send_event(CMD_DRAG, 20, 20);
        send_event(CMD_RELEASE, 0, 0);
        send_event(3'd5, 1, 1);
        send_event(3'd6, -1, -1);
        send_event(3'd7, 32767, -32768);
        send_event(CMD_PRESS_NEW, 0, 0);
        send_event(CMD_DRAG, 100, 50);
        send_event(CMD_HOVER, 100, 50);
        send_event(CMD_DRAG, 100, 50);
        send_event(CMD_DRAG, -32768, 32767);
        send_event(CMD_DRAG, 32767, -32768);
        send_event(CMD_RELEASE, 0, 0);
        send_event(CMD_PRESS_CONT, -32768, -32768);

        // spacing below the threshold, then zero spacing, then the smallest spacing above it
        set_view(24'd12, 4'd0, 21'd0, 21'd0, 14'd0);
        send_event(CMD_RELEASE, 0, 0);
        send_event(CMD_PRESS_NEW, 5, 5);
        send_event(CMD_DRAG, 500, 500);
        set_view(24'd0, 4'd0, 21'd0, 21'd0, 14'd0);
        send_event(CMD_DRAG, 900, 900);
        set_view(24'd13, 4'd0, 21'd0, 21'd0, 14'd0);
        send_event(CMD_DRAG, 1, 1);
        send_event(CMD_DRAG, 3, 2);
        send_event(CMD_RELEASE, 0, 0);

        // extreme view settings
        set_view(24'hFFFFFF, 4'd15, 21'h100000, 21'h0FFFFF, 14'h3FFF);
        send_event(CMD_PRESS_NEW, 32767, -32768);
        send_event(CMD_DRAG, -32768, 32767);
        send_event(CMD_RELEASE, 0, 0);
        set_view(24'd419431, 4'd15, 21'h0FFFFF, 21'h100000, 14'h3FFF);
        send_event(CMD_PRESS_NEW, -32768, 32767);
        send_event(CMD_DRAG, -32760, 32760);
        send_event(CMD_RELEASE, 0, 0);

        sent = 0;
        for (int phase = 0; phase < 7; phase++) begin
            zm = $urandom_range(0, 15);
            if (phase == 0) zm = 0;
            set_view(((24'($urandom_range(1, 24)) << (zm + $urandom_range(0, 4))) |
                      24'(zm > 10 ? $urandom : 0)),
                     4'(zm), 21'($urandom), 21'($urandom), 14'($urandom));
            no_idle = (phase == 3);
            for (int k = 0; k < 40; ) begin
                if ($urandom_range(0, 99) < 15) begin
                    random_point(1);
                    send_event(3'($urandom_range(0, 7)), cur_x, cur_y);
                    k++;
                end else begin
                    random_stroke();
                    k += 6;
                end
            end
            no_idle = 0;
        end

        wait_idle();
        $display("Checked %0d dabs from %0d pointer events (%0d with drop flag).",
                 sb.dabs_checked, sb.inputs_seen, sb.dropped_seen);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+hdl
hdl/bdss_pkg.sv
hdl/bdss_unit.sv
hdl/brush_dab_spacing_stepper_top.sv
tb/tb.sv
